### hw/rtl/egas_pkg.sv
// ----------------------------------------------------------------------------
// egas_pkg: shared definitions for the epsilon-greedy arm selector
// Field widths, transaction kind codes, fixed constants and the reward percent
// saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package egas_pkg;

	// field widths
	localparam int KIND_W   = 2;
	localparam int CIDX_W   = 2;
	localparam int AIDX_W   = 3;
	localparam int CNT_W    = 24;
	localparam int RAND_W   = 31;
	localparam int PCT_W    = 7;

	// default table geometry
	localparam int DEF_NUM_CONDITIONS = 4;
	localparam int DEF_NUM_ACTIONS    = 8;

	// percent scale and explore register reset
	localparam logic [PCT_W-1:0] PERCENT_SCALE = 7'd100;
	localparam logic [PCT_W-1:0] EXPLORE_RESET = 7'd10;

	// shared remainder unit: 4 dividend bits per cycle over a padded 32-bit word
	localparam int MOD_BITS_PER_STEP = 4;
	localparam int MOD_DVD_W         = 32;
	localparam int MOD_STEPS         = MOD_DVD_W / MOD_BITS_PER_STEP;
	localparam int MOD_CNT_W         = $clog2(MOD_STEPS);
	localparam int MOD_DVS_W         = 7;

	// transaction kinds; the fourth code is unused and ignored
	typedef enum logic [KIND_W-1:0] {
		KIND_WR_COUNT  = 2'd0,
		KIND_WR_REWARD = 2'd1,
		KIND_DECIDE    = 2'd2
	} kind_t;

	// clamp a written reward percent into 0..100
	function automatic logic [PCT_W-1:0] sat_percent(input logic signed [CNT_W-1:0] v);
		logic [PCT_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed(CNT_W'(PERCENT_SCALE))) begin
			r = PERCENT_SCALE;
		end else begin
			r = v[PCT_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/epsilon_greedy_arm_selector_core.sv
// ----------------------------------------------------------------------------
// epsilon_greedy_arm_selector_core: epsilon-greedy bandit arm selection
// Holds a signed count table and a reward percent table per (condition, action)
// and, on a decide transaction, samples a condition, explores or picks the best
// arm with random tie break, draws a reward and clears the count table.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in      | sink      | in_valid / in_stall    | kind, cond_index, action_index,
//          |           |                        | write_value, rand_* words
//  out     | source    | out_valid / out_stall  | chosen_action, chosen_condition,
//          |           |                        | reward_given, explored
//  cfg     | sink      | cfg_wr_en              | cfg_wr_data (explore percent)
//
// Write transactions leave the block idle; it is ready again on the next cycle.
// A decide makes four passes through the shared radix-16 remainder unit, on a
// greedy decide two scans of the count row at one entry per cycle, a reward
// read and compare, and a count-table clear at one row per cycle.
// After reset a clearing pass zeroes both tables; in_stall is high meanwhile.
// A finished result waits in the output register while the next transaction is
// accepted; only a second decide result waits.
`default_nettype none

module epsilon_greedy_arm_selector_core #(
	parameter int NUM_CONDITIONS = egas_pkg::DEF_NUM_CONDITIONS,
	parameter int NUM_ACTIONS    = egas_pkg::DEF_NUM_ACTIONS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration
	input  wire logic                                cfg_wr_en,
	input  wire logic [egas_pkg::PCT_W-1:0]          cfg_wr_data,
	// input channel
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [egas_pkg::KIND_W-1:0]         kind,
	input  wire logic [egas_pkg::CIDX_W-1:0]         cond_index,
	input  wire logic [egas_pkg::AIDX_W-1:0]         action_index,
	input  wire logic signed [egas_pkg::CNT_W-1:0]   write_value,
	input  wire logic [egas_pkg::RAND_W-1:0]         rand_condition,
	input  wire logic [egas_pkg::RAND_W-1:0]         rand_explore,
	input  wire logic [egas_pkg::RAND_W-1:0]         rand_arm,
	input  wire logic [egas_pkg::RAND_W-1:0]         rand_tie,
	input  wire logic [egas_pkg::RAND_W-1:0]         rand_reward,
	// output channel
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [egas_pkg::AIDX_W-1:0]              chosen_action,
	output logic [egas_pkg::CIDX_W-1:0]              chosen_condition,
	output logic                                     reward_given,
	output logic                                     explored
);
	import egas_pkg::*;

	localparam int CW    = (NUM_CONDITIONS > 1) ? $clog2(NUM_CONDITIONS) : 1;
	localparam int AW    = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
	localparam int CXW   = (CW > CIDX_W) ? CW : CIDX_W;
	localparam int AXW   = (AW > AIDX_W) ? AW : AIDX_W;
	localparam int TIE_W = $clog2(NUM_ACTIONS + 1);
	localparam int RNG_W = 7;

	localparam logic [CW-1:0]        COND_LAST = CW'(NUM_CONDITIONS - 1);
	localparam logic [AW-1:0]        ACT_LAST  = AW'(NUM_ACTIONS - 1);
	localparam logic [MOD_CNT_W-1:0] MOD_LAST  = MOD_CNT_W'(MOD_STEPS - 1);

	typedef enum logic [10:0] {
		S_IDLE      = 11'b000_0000_0001,
		S_MOD_COND  = 11'b000_0000_0010,
		S_MOD_EXPL  = 11'b000_0000_0100,
		S_MOD_REW   = 11'b000_0000_1000,
		S_MOD_ARM   = 11'b000_0001_0000,
		S_SCAN_MAX  = 11'b000_0010_0000,
		S_MOD_TIE   = 11'b000_0100_0000,
		S_SCAN_PICK = 11'b000_1000_0000,
		S_REW_RD    = 11'b001_0000_0000,
		S_REW_CMP   = 11'b010_0000_0000,
		S_CLEAR     = 11'b100_0000_0000
	} egas_state_t;

	// control state
	egas_state_t             state_q;
	logic [MOD_CNT_W-1:0]    mod_cnt_q;
	logic [CW-1:0]           clr_row_q;
	logic                    clr_rew_q;
	logic [PCT_W-1:0]        explore_pct_q;
	logic                    out_valid_q;

	// decision payload
	logic [RAND_W-1:0]       rnd_cond_q, rnd_expl_q, rnd_arm_q, rnd_tie_q, rnd_rew_q;
	logic [CW-1:0]           cond_q;
	logic [AW-1:0]           arm_q;
	logic                    explore_q;
	logic [PCT_W-1:0]        rew_rem_q;
	logic [AW-1:0]           idx_q;
	logic signed [CNT_W-1:0] top_q;
	logic [TIE_W-1:0]        ties_q;
	logic [TIE_W-1:0]        pick_q;
	logic [TIE_W-1:0]        seen_q;

	// output register
	logic [AIDX_W-1:0]       out_action_q;
	logic [CIDX_W-1:0]       out_cond_q;
	logic                    out_reward_q;
	logic                    out_expl_q;

	// table storage
	logic signed [CNT_W-1:0] count_mem [NUM_CONDITIONS][NUM_ACTIONS];
	logic [PCT_W-1:0]        rew_mem   [NUM_CONDITIONS][NUM_ACTIONS];
	logic signed [CNT_W-1:0] cnt_row_q [NUM_ACTIONS];
	logic [PCT_W-1:0]        rew_rd_q;

	// shared remainder unit
	logic [MOD_DVD_W-1:0]    mod_sh_q;
	logic [MOD_DVS_W-1:0]    mod_rem_q;
	logic [RAND_W-1:0]       mod_src;
	logic [MOD_DVS_W-1:0]    mod_dvs;
	logic [MOD_DVD_W-1:0]    mod_cur;
	logic [MOD_DVS_W-1:0]    mod_rem_n;
	logic                    in_mod;
	logic                    mod_last;

	// handshakes and write decode
	logic                    in_acc;
	logic                    out_free;
	logic                    wr_in_range;
	logic                    wr_cnt;
	logic                    wr_rew;
	logic [CW-1:0]           wr_row;
	logic [AW-1:0]           wr_col;
	logic signed [CNT_W-1:0] scan_entry;
	logic                    greedy_hit;
	logic [CXW-1:0]          cond_x;
	logic [AXW-1:0]          arm_x;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	assign chosen_action    = out_action_q;
	assign chosen_condition = out_cond_q;
	assign reward_given     = out_reward_q;
	assign explored         = out_expl_q;

	// table write decode; out-of-range writes are dropped
	assign wr_in_range = (RNG_W'(cond_index) < RNG_W'(NUM_CONDITIONS)) &&
	                     (RNG_W'(action_index) < RNG_W'(NUM_ACTIONS));
	assign wr_cnt = in_acc && wr_in_range && (kind == KIND_WR_COUNT);
	assign wr_rew = in_acc && wr_in_range && (kind == KIND_WR_REWARD);
	assign wr_row = CW'(cond_index);
	assign wr_col = AW'(action_index);

	// row scan taps
	assign scan_entry = cnt_row_q[idx_q];
	assign greedy_hit = (scan_entry == top_q) && (seen_q == pick_q);

	// masked result fields
	assign cond_x = CXW'(cond_q);
	assign arm_x  = AXW'(arm_q);

	// remainder operand select
	always_comb begin
		in_mod  = 1'b1;
		mod_src = rnd_rew_q;
		mod_dvs = PERCENT_SCALE;
		case (state_q)
			S_MOD_COND: begin
				mod_src = rnd_cond_q;
				mod_dvs = MOD_DVS_W'(NUM_CONDITIONS);
			end
			S_MOD_EXPL: begin
				mod_src = rnd_expl_q;
				mod_dvs = PERCENT_SCALE;
			end
			S_MOD_REW: begin
				mod_src = rnd_rew_q;
				mod_dvs = PERCENT_SCALE;
			end
			S_MOD_ARM: begin
				mod_src = rnd_arm_q;
				mod_dvs = MOD_DVS_W'(NUM_ACTIONS);
			end
			S_MOD_TIE: begin
				mod_src = rnd_tie_q;
				mod_dvs = MOD_DVS_W'(ties_q);
			end
			default: begin
				in_mod = 1'b0;
			end
		endcase
	end

	assign mod_last = in_mod && (mod_cnt_q == MOD_LAST);

	// radix-16 restoring remainder step, MSB first
	always_comb begin
		logic [MOD_DVS_W:0] t;
		logic [MOD_DVS_W-1:0] r;
		mod_cur = (mod_cnt_q == '0) ? MOD_DVD_W'(mod_src) : mod_sh_q;
		r = (mod_cnt_q == '0) ? '0 : mod_rem_q;
		for (int k = 0; k < MOD_BITS_PER_STEP; k++) begin
			t = {r, mod_cur[MOD_DVD_W-1-k]};
			if (t >= {1'b0, mod_dvs}) begin
				t = t - {1'b0, mod_dvs};
			end
			r = t[MOD_DVS_W-1:0];
		end
		mod_rem_n = r;
	end

	always_ff @(posedge clk) begin
		mod_sh_q  <= mod_cur << MOD_BITS_PER_STEP;
		mod_rem_q <= mod_rem_n;
	end

	// explore percent register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			explore_pct_q <= EXPLORE_RESET;
		end else if (cfg_wr_en) begin
			explore_pct_q <= cfg_wr_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			mod_cnt_q   <= '0;
			clr_row_q   <= '0;
			clr_rew_q   <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			// output register: load a finished decision, else drain when taken
			if (state_q == S_REW_CMP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_mod) begin
				mod_cnt_q <= mod_cnt_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && (kind == KIND_DECIDE)) begin
						mod_cnt_q <= '0;
						state_q   <= S_MOD_COND;
					end
				end
				S_MOD_COND: begin
					if (mod_last) begin
						state_q <= S_MOD_EXPL;
					end
				end
				S_MOD_EXPL: begin
					if (mod_last) begin
						state_q <= S_MOD_REW;
					end
				end
				S_MOD_REW: begin
					if (mod_last) begin
						state_q <= explore_q ? S_MOD_ARM : S_SCAN_MAX;
					end
				end
				S_MOD_ARM: begin
					if (mod_last) begin
						state_q <= S_REW_RD;
					end
				end
				S_SCAN_MAX: begin
					if (idx_q == ACT_LAST) begin
						state_q <= S_MOD_TIE;
					end
				end
				S_MOD_TIE: begin
					if (mod_last) begin
						state_q <= S_SCAN_PICK;
					end
				end
				S_SCAN_PICK: begin
					if (greedy_hit || (idx_q == ACT_LAST)) begin
						state_q <= S_REW_RD;
					end
				end
				S_REW_RD: begin
					state_q <= S_REW_CMP;
				end
				S_REW_CMP: begin
					if (out_free) begin
						clr_row_q   <= '0;
						clr_rew_q   <= 1'b0;
						state_q     <= S_CLEAR;
					end
				end
				S_CLEAR: begin
					clr_row_q <= clr_row_q + 1'b1;
					if (clr_row_q == COND_LAST) begin
						clr_rew_q <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// decision datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rnd_cond_q <= rand_condition;
			rnd_expl_q <= rand_explore;
			rnd_arm_q  <= rand_arm;
			rnd_tie_q  <= rand_tie;
			rnd_rew_q  <= rand_reward;
		end
		if (mod_last) begin
			case (state_q)
				S_MOD_COND: cond_q    <= CW'(mod_rem_n);
				S_MOD_EXPL: explore_q <= (mod_rem_n < explore_pct_q);
				S_MOD_REW: begin
					rew_rem_q <= mod_rem_n;
					idx_q     <= '0;
				end
				S_MOD_ARM:  arm_q     <= AW'(mod_rem_n);
				S_MOD_TIE: begin
					pick_q <= TIE_W'(mod_rem_n);
					seen_q <= '0;
					idx_q  <= '0;
				end
				default: begin
				end
			endcase
		end
		// first pass: row maximum and how many entries share it
		if (state_q == S_SCAN_MAX) begin
			idx_q <= idx_q + 1'b1;
			if (idx_q == '0 || scan_entry > top_q) begin
				top_q  <= scan_entry;
				ties_q <= TIE_W'(1);
			end else if (scan_entry == top_q) begin
				ties_q <= ties_q + 1'b1;
			end
		end
		// second pass: walk to the chosen tied arm
		if (state_q == S_SCAN_PICK) begin
			idx_q <= idx_q + 1'b1;
			if (greedy_hit) begin
				arm_q <= idx_q;
			end else if (scan_entry == top_q) begin
				seen_q <= seen_q + 1'b1;
			end
		end
		// result capture
		if (state_q == S_REW_CMP && out_free) begin
			out_action_q <= arm_x[AIDX_W-1:0];
			out_cond_q   <= cond_x[CIDX_W-1:0];
			out_reward_q <= (rew_rem_q < rew_rd_q);
			out_expl_q   <= explore_q;
		end
	end

	// tables: row clear, single-entry writes, registered reads
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) begin
			for (int l = 0; l < NUM_ACTIONS; l++) begin
				count_mem[clr_row_q][l] <= '0;
				if (clr_rew_q) begin
					rew_mem[clr_row_q][l] <= '0;
				end
			end
		end else if (wr_cnt) begin
			count_mem[wr_row][wr_col] <= write_value;
		end else if (wr_rew) begin
			rew_mem[wr_row][wr_col] <= sat_percent(write_value);
		end
		cnt_row_q <= count_mem[cond_q];
		rew_rd_q  <= rew_mem[cond_q][arm_q];
	end

`ifndef SYNTHESIS
	// a finished remainder is always below its divisor
	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		mod_last |-> (mod_rem_n < mod_dvs))
		else $error("remainder not below divisor");

	// the sampled condition stays inside the table
	a_cond_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN_MAX || state_q == S_REW_RD || state_q == S_REW_CMP) |->
		(RNG_W'(cond_q) < RNG_W'(NUM_CONDITIONS)))
		else $error("condition index out of range");

	// the tie count is never zero and never above the row length
	a_ties_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOD_TIE) |->
		(ties_q != '0) && (RNG_W'(ties_q) <= RNG_W'(NUM_ACTIONS)))
		else $error("tie count out of range");

	// the pick scan finds its arm by the last entry at the latest
	a_pick_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN_PICK && idx_q == ACT_LAST) |-> greedy_hit)
		else $error("tied arm not found");

	// a result is loaded only when the output register is free
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REW_CMP && out_valid_q && out_stall) |=> (state_q == S_REW_CMP))
		else $error("result overwrote a pending transaction");
`endif

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the epsilon-greedy arm selector
// Loads count and reward percent tables through write transactions, issues
// decide transactions with chosen random words, and compares every decision
// against an in-bench model of the table logic. Both channels idle at random,
// and the explore percent is stepped through its extremes between phases.
// ----------------------------------------------------------------------------
module tb_top;
	import egas_pkg::*;

	localparam int N_COND        = DEF_NUM_CONDITIONS;
	localparam int N_ACT         = DEF_NUM_ACTIONS;
	localparam int PCT_FULL      = PERCENT_SCALE;
	localparam int DIRECTED_N    = 22;
	localparam int PHASE_ITEMS   = 107;
	// long enough for a greedy decide to finish, plus margin
	localparam int SETTLE_CYCLES = 34 + 2 * N_ACT + N_COND + 26;
	localparam int HOLD_CYCLES   = 400;
	localparam int LIMIT_CYCLES  = 500000;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};
	localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
	localparam logic [RAND_W-1:0] RAND_ONES = '1;

	typedef struct {
		logic [KIND_W-1:0]        kind;
		logic [CIDX_W-1:0]        cond;
		logic [AIDX_W-1:0]        action;
		logic signed [CNT_W-1:0]  value;
		logic [RAND_W-1:0]        r_cond;
		logic [RAND_W-1:0]        r_explore;
		logic [RAND_W-1:0]        r_arm;
		logic [RAND_W-1:0]        r_tie;
		logic [RAND_W-1:0]        r_reward;
	} bandit_item_t;

	typedef struct {
		logic [AIDX_W-1:0] action;
		logic [CIDX_W-1:0] cond;
		logic              reward;
		logic              explored;
	} decision_t;

	// Table model plus queue of decisions still owed by the block
	class decision_scoreboard;
		logic signed [CNT_W-1:0] counts [N_COND*N_ACT];
		logic [PCT_W-1:0]        reward_pct [N_COND*N_ACT];
		logic [PCT_W-1:0]        explore_pct;
		decision_t               owed[$];
		int                      errors;
		int                      decides;
		int                      explored_n;
		int                      rewarded_n;

		function new();
			for (int i = 0; i < N_COND*N_ACT; i++) begin
				counts[i] = '0;
				reward_pct[i] = '0;
			end
			explore_pct = EXPLORE_RESET;
			errors = 0;
			decides = 0;
			explored_n = 0;
			rewarded_n = 0;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		// highest count in the row; ties resolved by r_tie mod tie count
		function int unsigned greedy_arm(int unsigned row, logic [RAND_W-1:0] r_tie);
			logic signed [CNT_W-1:0] top;
			int unsigned ties;
			int unsigned pick;
			int unsigned seen;
			top = counts[row*N_ACT];
			for (int a = 1; a < N_ACT; a++)
				if (counts[row*N_ACT+a] > top)
					top = counts[row*N_ACT+a];
			ties = 0;
			for (int a = 0; a < N_ACT; a++)
				if (counts[row*N_ACT+a] == top)
					ties++;
			pick = r_tie % ties;
			seen = 0;
			for (int a = 0; a < N_ACT; a++) begin
				if (counts[row*N_ACT+a] == top) begin
					if (seen == pick)
						return a;
					seen++;
				end
			end
			return 0;
		endfunction

		function void note_input(bandit_item_t it);
			int unsigned idx;
			int unsigned cond;
			int unsigned arm;
			decision_t d;
			if (it.kind == KIND_WR_COUNT || it.kind == KIND_WR_REWARD) begin
				if (it.cond < N_COND && it.action < N_ACT) begin
					idx = it.cond * N_ACT + it.action;
					if (it.kind == KIND_WR_COUNT)
						counts[idx] = it.value;
					else if (it.value < 0)
						reward_pct[idx] = '0;
					else if (it.value > PCT_FULL)
						reward_pct[idx] = PERCENT_SCALE;
					else
						reward_pct[idx] = it.value[PCT_W-1:0];
				end
			end else if (it.kind == KIND_DECIDE) begin
				cond = it.r_cond % N_COND;
				if ((it.r_explore % PCT_FULL) < explore_pct) begin
					d.explored = 1'b1;
					arm = it.r_arm % N_ACT;
				end else begin
					d.explored = 1'b0;
					arm = greedy_arm(cond, it.r_tie);
				end
				d.reward = ((it.r_reward % PCT_FULL) < reward_pct[cond*N_ACT+arm]);
				d.action = arm[AIDX_W-1:0];
				d.cond = cond[CIDX_W-1:0];
				// every decision wipes the count table
				for (int i = 0; i < N_COND*N_ACT; i++)
					counts[i] = '0;
				owed.push_back(d);
				decides++;
				explored_n += d.explored;
				rewarded_n += d.reward;
			end
		endfunction

		function void check_result(decision_t got);
			decision_t want;
			if (owed.size() == 0) begin
				$display("%0t ERROR: extra decision, action %0d cond %0d reward %0d expl %0d",
					$time, got.action, got.cond, got.reward, got.explored);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (got.action !== want.action) begin
				$display("%0t ERROR: chosen_action expected %0d, actual %0d",
					$time, want.action, got.action);
				errors++;
			end
			if (got.cond !== want.cond) begin
				$display("%0t ERROR: chosen_condition expected %0d, actual %0d",
					$time, want.cond, got.cond);
				errors++;
			end
			if (got.reward !== want.reward) begin
				$display("%0t ERROR: reward_given expected %0d, actual %0d",
					$time, want.reward, got.reward);
				errors++;
			end
			if (got.explored !== want.explored) begin
				$display("%0t ERROR: explored expected %0d, actual %0d",
					$time, want.explored, got.explored);
				errors++;
			end
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_wr_en = 1'b0;
	logic [PCT_W-1:0]           cfg_wr_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [KIND_W-1:0]          kind = '0;
	logic [CIDX_W-1:0]          cond_index = '0;
	logic [AIDX_W-1:0]          action_index = '0;
	logic signed [CNT_W-1:0]    write_value = '0;
	logic [RAND_W-1:0]          rand_condition = '0;
	logic [RAND_W-1:0]          rand_explore = '0;
	logic [RAND_W-1:0]          rand_arm = '0;
	logic [RAND_W-1:0]          rand_tie = '0;
	logic [RAND_W-1:0]          rand_reward = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [AIDX_W-1:0]          chosen_action;
	logic [CIDX_W-1:0]          chosen_condition;
	logic                       reward_given;
	logic                       explored;

	decision_scoreboard sb = new();
	int  sent = 0;
	int  settings_used = 0;
	int  cycle_count = 0;
	bit  calm = 1'b0;
	bit  hold_off_req = 1'b0;

	epsilon_greedy_arm_selector_core #(
		.NUM_CONDITIONS(N_COND),
		.NUM_ACTIONS(N_ACT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.cond_index(cond_index),
		.action_index(action_index),
		.write_value(write_value),
		.rand_condition(rand_condition),
		.rand_explore(rand_explore),
		.rand_arm(rand_arm),
		.rand_tie(rand_tie),
		.rand_reward(rand_reward),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.chosen_action(chosen_action),
		.chosen_condition(chosen_condition),
		.reward_given(reward_given),
		.explored(explored)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("Run limit of %0d cycles reached", LIMIT_CYCLES);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// idle length: mostly none or short, now and then long; none in calm stretches
	function automatic int pick_pause();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic bandit_item_t make_item(logic [KIND_W-1:0] k, int c, int a,
		logic signed [CNT_W-1:0] v);
		bandit_item_t it;
		it.kind = k;
		it.cond = CIDX_W'(c);
		it.action = AIDX_W'(a);
		it.value = v;
		it.r_cond = RAND_W'($urandom);
		it.r_explore = RAND_W'($urandom);
		it.r_arm = RAND_W'($urandom);
		it.r_tie = RAND_W'($urandom);
		it.r_reward = RAND_W'($urandom);
		return it;
	endfunction

	// decide aimed at one condition row most of the time
	function automatic bandit_item_t decide_on(int c);
		bandit_item_t it;
		it = make_item(KIND_DECIDE, $urandom_range(0, 3), $urandom_range(0, 7),
			CNT_W'($urandom));
		if ($urandom_range(0, 99) < 85)
			it.r_cond = (it.r_cond & ~RAND_W'(3)) | RAND_W'(c);
		return it;
	endfunction

	// Input driver: one transaction, returns at its accepting edge
	task automatic send_item(input bandit_item_t it);
		int gap;
		gap = pick_pause();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= it.kind;
		cond_index <= it.cond;
		action_index <= it.action;
		write_value <= it.value;
		rand_condition <= it.r_cond;
		rand_explore <= it.r_explore;
		rand_arm <= it.r_arm;
		rand_tie <= it.r_tie;
		rand_reward <= it.r_reward;
		do @(posedge clk); while (in_stall);
		sb.note_input(it);
		sent++;
	endtask

	// Explore percent update, only once the block has drained
	task automatic write_explore(input logic [PCT_W-1:0] pct);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= pct;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.explore_pct = pct;
		settings_used++;
	endtask

	// Edge cases: saturation, extreme counts, unused kind, full ties, all-negative row
	task automatic directed_checks();
		bandit_item_t it;
		send_item(make_item(KIND_WR_REWARD, 0, 0, CNT_MAX));
		send_item(make_item(KIND_WR_REWARD, 0, 1, CNT_MIN));
		send_item(make_item(KIND_WR_REWARD, 3, 7, 24'sd101));
		send_item(make_item(KIND_WR_REWARD, 3, 6, 24'sd100));
		send_item(make_item(KIND_WR_REWARD, 2, 3, -24'sd1));
		send_item(make_item(KIND_WR_COUNT, 3, 7, CNT_MAX));
		send_item(make_item(KIND_WR_COUNT, 3, 0, CNT_MIN));
		it = make_item(KIND_UNUSED, 3, 7, '1);
		send_item(it);
		// greedy on row 3, best arm 7, full reward percent
		it = make_item(KIND_DECIDE, 0, 0, '0);
		it.r_cond = RAND_ONES;
		it.r_explore = 31'd99;
		it.r_reward = RAND_ONES;
		send_item(it);
		// row 0 all zero after the clear: eight-way tie
		it = make_item(KIND_DECIDE, 0, 0, '0);
		it.r_cond = '0;
		it.r_explore = 31'd99;
		it.r_tie = RAND_ONES;
		send_item(it);
		// explore with an arm word equal to the row length
		it = make_item(KIND_DECIDE, 0, 0, '0);
		it.r_cond = '0;
		it.r_explore = '0;
		it.r_arm = 31'd8;
		it.r_reward = '0;
		send_item(it);
		for (int a = 0; a < N_ACT; a++)
			send_item(make_item(KIND_WR_COUNT, 1, a,
				(a == 5) ? -24'sd1 : CNT_MIN + CNT_W'(a)));
		it = make_item(KIND_DECIDE, 0, 0, '0);
		it.r_cond = 31'd1;
		it.r_explore = 31'd50;
		send_item(it);
		it = make_item(KIND_DECIDE, 0, 0, '0);
		it.r_cond = 31'd2;
		it.r_explore = RAND_ONES;
		it.r_arm = RAND_ONES;
		send_item(it);
		send_item(make_item(KIND_UNUSED, 0, 0, '0));
	endtask

	// One episode: load a row (and maybe rewards), some noise, then a decide
	task automatic run_episode();
		int c;
		int style;
		int n;
		logic signed [CNT_W-1:0] v;
		bandit_item_t it;
		c = $urandom_range(0, N_COND-1);
		style = $urandom_range(0, 4);
		calm = ($urandom_range(0, 5) == 0);
		if ($urandom_range(0, 2) == 0) begin
			n = $urandom_range(1, N_ACT);
			for (int i = 0; i < n; i++) begin
				v = ($urandom_range(0, 4) == 0) ? CNT_W'($urandom) :
					CNT_W'($urandom_range(0, 100));
				send_item(make_item(KIND_WR_REWARD, c, $urandom_range(0, N_ACT-1), v));
			end
		end
		n = (style == 2) ? N_ACT : $urandom_range(0, N_ACT);
		for (int i = 0; i < n; i++) begin
			case (style)
				0: v = CNT_W'($signed($urandom_range(0, 2)) - 1);
				1: v = CNT_W'($urandom);
				2: v = {1'b1, (CNT_W-1)'($urandom)};
				3: v = 24'sd7;
				default: v = CNT_W'($urandom_range(0, 20));
			endcase
			send_item(make_item(KIND_WR_COUNT, c,
				(style == 2) ? i : $urandom_range(0, N_ACT-1), v));
		end
		if ($urandom_range(0, 4) == 0) begin
			it = make_item(KIND_W'($urandom_range(0, 3)), $urandom_range(0, 3),
				$urandom_range(0, 7), CNT_W'($urandom));
			send_item(it);
		end
		send_item(decide_on(c));
	endtask

	// Output stall pattern, with one long hold-off on request
	initial begin : out_stall_gen
		int pause;
		@(posedge arst_n);
		forever begin
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			if (hold_off_req) begin
				pause = HOLD_CYCLES;
				hold_off_req = 1'b0;
			end else begin
				pause = pick_pause();
			end
			if (pause > 0) begin
				out_stall <= 1'b1;
				repeat (pause) @(posedge clk);
			end
		end
	end

	// Result monitor
	always @(posedge clk) begin : result_mon
		decision_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.action = chosen_action;
			got.cond = chosen_condition;
			got.reward = reward_given;
			got.explored = explored;
			sb.check_result(got);
		end
	end

	// Main sequence
	initial begin : main_seq
		logic [PCT_W-1:0] explore_steps [7];
		explore_steps = '{7'd0, 7'd127, 7'd100, 7'd10, 7'd1, 7'd99, 7'd50};
		explore_steps[6] = PCT_W'($urandom_range(0, 127));
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_checks();
		for (int p = 0; p < 7; p++) begin
			write_explore(explore_steps[p]);
			// block fills while the receiver holds off
			if (p == 2)
				hold_off_req = 1'b1;
			while (sent < DIRECTED_N + (p + 1) * PHASE_ITEMS)
				run_episode();
		end
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Run covered %0d transactions and %0d decisions (%0d explored, %0d rewarded)",
			sent, sb.decides, sb.explored_n, sb.rewarded_n);
		$display("across %0d explore settings from 0 to 127, with %0d mismatches",
			settings_used, sb.errors);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
